// File: design/dgm_pkg.sv
`default_nettype none

package dgm_pkg;

    localparam int COL_W        = 11;
    localparam int ROW_W        = 11;
    localparam int DIM_W        = 12;
    localparam int SLOTS        = 8;
    localparam int SLOT_W       = 3;
    localparam int TAPS         = 5;
    localparam int SEL_W        = 3;
    localparam int KERNELS      = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int WIDTH_LIMIT  = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int WIDTH_RESET  = 1920;
    localparam int HEIGHT_RESET = 1080;
    localparam int MIN_DIM      = 3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [SLOT_W-1:0]       slot_t;
    typedef logic signed [DIM_W+1:0] spos_t;
    typedef logic signed [4:0]       coef_t;

    typedef struct packed {
        logic                         wr;
        slot_t                        wr_slot;
        logic [COL_W-1:0]             col;
        logic                         fetch;
        logic [TAPS-1:0][SLOT_W-1:0]  row_slot;
        logic                         emit;
        logic [TAPS-1:0][SEL_W-1:0]   col_sel;
        logic [ROW_W-1:0]             orow;
        logic [COL_W-1:0]             ocol;
        logic                         last;
    } cmd_t;

    // 5x5 kernels, row major: horizontal, two diagonals, vertical
    localparam coef_t KERNEL [KERNELS][TAPS*TAPS] = '{
        '{ 0, 0, 0, 0, 0,   1, 3, 8, 3, 1,   0, 0, 0, 0, 0,  -1,-3,-8,-3,-1,   0, 0, 0, 0, 0 },
        '{ 0, 0, 1, 0, 0,   0, 8, 3, 0, 0,   1, 3, 0,-3,-1,   0, 0,-3,-8, 0,   0, 0,-1, 0, 0 },
        '{ 0, 0, 1, 0, 0,   0, 0, 3, 8, 0,  -1,-3, 0, 3, 1,   0,-8,-3, 0, 0,   0, 0,-1, 0, 0 },
        '{ 0, 1, 0,-1, 0,   0, 3, 0,-3, 0,   0, 8, 0,-8, 0,   0, 3, 0,-3, 0,   0, 1, 0,-1, 0 }
    };

    // reflect-101 border index
    function automatic logic [DIM_W-1:0] mirror(input spos_t p, input logic [DIM_W-1:0] n);
        spos_t q;
        spos_t m;
        m = spos_t'(n);
        q = (p < 0) ? -p : p;
        if (q >= m)
            q = (m <<< 1) - spos_t'(2) - q;
        if (q < 0)
            q = '0;
        if (q >= m)
            q = m - spos_t'(1);
        return q[DIM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/dgm_in_if.sv
`default_nettype none

interface dgm_in_if #(parameter int PIXEL_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

`default_nettype wire

// File: design/dgm_out_if.sv
`default_nettype none

interface dgm_out_if #(parameter int PIXEL_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS+3:0] gradient_x16;
    logic [10:0]           out_row;
    logic [10:0]           out_col;
    logic                  frame_last;

    modport source (output valid, output gradient_x16, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input gradient_x16, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

`default_nettype wire

// File: design/dgm_front.sv
`default_nettype none

module dgm_front
    import dgm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    dgm_in_if.sink                pixel_stream,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [DIM_W-1:0] cfg_data,
    input  wire logic             queue_full,
    output logic                  push,
    output cmd_t                  cmd
);

    localparam int WLIM = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
    localparam logic [DIM_W-1:0] W_MAX = DIM_W'(WLIM);
    localparam logic [DIM_W-1:0] W_RST = DIM_W'((WIDTH_RESET < WLIM) ? WIDTH_RESET : WLIM);
    localparam logic [DIM_W-1:0] H_MAX = DIM_W'(HEIGHT_LIMIT);
    localparam logic [DIM_W-1:0] H_RST = DIM_W'(HEIGHT_RESET);
    localparam logic [DIM_W-1:0] D_MIN = DIM_W'(MIN_DIM);

    logic [DIM_W-1:0] w_reg, w_next, h_reg, h_next;
    logic [ROW_W-1:0] irow_reg, irow_next;
    logic [COL_W-1:0] icol_reg, icol_next;
    logic             done_reg, done_next;
    logic [DIM_W-1:0] frow_reg, frow_next;
    logic [COL_W-1:0] fcol_reg, fcol_next;
    logic [ROW_W-1:0] orow_reg, orow_next;
    logic [COL_W-1:0] ocol_reg, ocol_next;

    logic             accept, pix_item, active, fetch, emit, last;
    logic [DIM_W-1:0] icol_inc, irow_inc, fcol_inc, ocol_inc;
    spos_t            rpos, cpos;
    logic [DIM_W-1:0] rm, cm, cdiff, sat_val;

    function automatic logic [DIM_W-1:0] sat(input logic [DIM_W-1:0] v,
                                             input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (r < D_MIN)
            r = D_MIN;
        if (r > hi)
            r = hi;
        return r;
    endfunction

    assign pixel_stream.ready = !queue_full;
    assign accept   = pixel_stream.valid && pixel_stream.ready;
    assign pix_item = (pixel_stream.op == OP_PIXEL) && !done_reg;
    assign active   = pix_item || done_reg;
    assign fetch    = pix_item ? (irow_reg >= ROW_W'(2)) : done_reg;
    assign emit     = pix_item ? ((irow_reg >= ROW_W'(3)) ||
                                  ((irow_reg == ROW_W'(2)) && (icol_reg >= COL_W'(2))))
                               : done_reg;
    assign last     = emit && (DIM_W'(orow_reg) == h_reg - DIM_W'(1))
                           && (DIM_W'(ocol_reg) == w_reg - DIM_W'(1));
    assign push     = accept && active;

    always_comb
    begin
        cmd.wr      = pix_item;
        cmd.wr_slot = irow_reg[SLOT_W-1:0];
        cmd.col     = pix_item ? icol_reg : fcol_reg;
        cmd.fetch   = fetch;
        cmd.emit    = emit;
        cmd.orow    = orow_reg;
        cmd.ocol    = ocol_reg;
        cmd.last    = last;
        rpos  = '0;
        cpos  = '0;
        rm    = '0;
        cm    = '0;
        cdiff = '0;
        for (int d = 0; d < TAPS; d++)
        begin
            rpos = spos_t'(frow_reg) + spos_t'(d) - spos_t'(2);
            rm   = mirror(rpos, h_reg);
            cmd.row_slot[d] = rm[SLOT_W-1:0];
            cpos  = spos_t'(ocol_reg) + spos_t'(d) - spos_t'(2);
            cm    = mirror(cpos, w_reg);
            cdiff = cm - DIM_W'(ocol_reg) + DIM_W'(2);
            cmd.col_sel[d] = cdiff[SEL_W-1:0];
        end
    end

    always_comb
    begin
        w_next    = w_reg;
        h_next    = h_reg;
        irow_next = irow_reg;
        icol_next = icol_reg;
        done_next = done_reg;
        frow_next = frow_reg;
        fcol_next = fcol_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        icol_inc  = DIM_W'(icol_reg) + DIM_W'(1);
        irow_inc  = DIM_W'(irow_reg) + DIM_W'(1);
        fcol_inc  = DIM_W'(fcol_reg) + DIM_W'(1);
        ocol_inc  = DIM_W'(ocol_reg) + DIM_W'(1);
        sat_val   = '0;
        if (push)
        begin
            if (pix_item)
            begin
                if (icol_inc >= w_reg)
                begin
                    icol_next = '0;
                    if (irow_inc >= h_reg)
                    begin
                        irow_next = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        irow_next = irow_inc[ROW_W-1:0];
                    end
                end
                else
                begin
                    icol_next = icol_inc[COL_W-1:0];
                end
            end
            if (fetch)
            begin
                if (fcol_inc >= w_reg)
                begin
                    fcol_next = '0;
                    frow_next = frow_reg + DIM_W'(1);
                end
                else
                begin
                    fcol_next = fcol_inc[COL_W-1:0];
                end
            end
            if (emit)
            begin
                if (ocol_inc >= w_reg)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + ROW_W'(1);
                end
                else
                begin
                    ocol_next = ocol_inc[COL_W-1:0];
                end
            end
            if (last)
            begin
                irow_next = '0;
                icol_next = '0;
                done_next = 1'b0;
                frow_next = '0;
                fcol_next = '0;
                orow_next = '0;
                ocol_next = '0;
            end
        end
        if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                sat_val = sat(cfg_data, W_MAX);
                w_next  = sat_val;
            end
            else
            begin
                sat_val = sat(cfg_data, H_MAX);
                h_next  = sat_val;
            end
            irow_next = '0;
            icol_next = '0;
            done_next = 1'b0;
            frow_next = '0;
            fcol_next = '0;
            orow_next = '0;
            ocol_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= W_RST;
            h_reg    <= H_RST;
            irow_reg <= '0;
            icol_reg <= '0;
            done_reg <= 1'b0;
            frow_reg <= '0;
            fcol_reg <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
        end
        else
        begin
            w_reg    <= w_next;
            h_reg    <= h_next;
            irow_reg <= irow_next;
            icol_reg <= icol_next;
            done_reg <= done_next;
            frow_reg <= frow_next;
            fcol_reg <= fcol_next;
            orow_reg <= orow_next;
            ocol_reg <= ocol_next;
        end
    end

    a_done_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (irow_reg == '0) && (icol_reg == '0))
        else $error("input counters not cleared after frame end");

    a_out_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(ocol_reg) < w_reg)
        else $error("output column beyond line width");

endmodule

`default_nettype wire

// File: design/dgm_queue.sv
`default_nettype none

module dgm_queue
    import dgm_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] din,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      dout,
    output logic                   empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] buf_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;

    assign full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + (PW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= (PW+1)'(QUEUE_DEPTH)) && !(push && full) && !(pop && empty))
        else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// File: design/dgm_back.sv
`default_nettype none

module dgm_back
    import dgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  empty,
    input  wire cmd_t                  cmd,
    input  wire logic [PIXEL_BITS-1:0] pix,
    output logic                       pop,
    dgm_out_if.source                  result_stream
);

    localparam int DEPTH = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = PIXEL_BITS + 6;
    localparam int GW    = PIXEL_BITS + 4;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic signed [SW-1:0]  sum_t;
    typedef logic [SW-1:0]         mag_t;

    logic              adv;
    logic [AW-1:0]     addr;
    pix_t              mem [SLOTS][DEPTH];
    pix_t              rd_reg [SLOTS];

    // fetch stage
    logic                        b_valid_reg, b_emit_reg, b_byp_reg, b_last_reg;
    slot_t                       b_byp_slot_reg;
    pix_t                        b_pix_reg;
    logic [TAPS-1:0][SLOT_W-1:0] b_row_slot_reg;
    logic [TAPS-1:0][SEL_W-1:0]  b_col_sel_reg;
    logic [ROW_W-1:0]            b_row_reg;
    logic [COL_W-1:0]            b_col_reg;
    pix_t                        col_vals [TAPS];

    // window stage
    pix_t                        sr_reg [TAPS][TAPS];
    logic                        c_valid_reg, c_last_reg;
    logic [TAPS-1:0][SEL_W-1:0]  c_col_sel_reg;
    logic [ROW_W-1:0]            c_row_reg;
    logic [COL_W-1:0]            c_col_reg;
    pix_t                        win [TAPS][TAPS];
    sum_t                        part [KERNELS][TAPS];

    // row partial sums
    sum_t                        p_part_reg [KERNELS][TAPS];
    logic                        p_valid_reg, p_last_reg;
    logic [ROW_W-1:0]            p_row_reg;
    logic [COL_W-1:0]            p_col_reg;
    sum_t                        ksum [KERNELS];

    // kernel sums
    sum_t                        s_sum_reg [KERNELS];
    logic                        s_valid_reg, s_last_reg;
    logic [ROW_W-1:0]            s_row_reg;
    logic [COL_W-1:0]            s_col_reg;
    mag_t                        mag, best;

    logic                        out_valid_reg;
    logic [GW-1:0]               out_grad_reg;
    logic [ROW_W-1:0]            out_row_reg;
    logic [COL_W-1:0]            out_col_reg;
    logic                        out_last_reg;

    assign adv  = !out_valid_reg || result_stream.ready;
    assign pop  = adv && !empty;
    assign addr = cmd.col[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cmd.wr)
                mem[cmd.wr_slot][addr] <= pix;
            for (int b = 0; b < SLOTS; b++)
                rd_reg[b] <= mem[b][addr];
        end
    end

    // same-word write bypass
    always_comb
    begin
        for (int d = 0; d < TAPS; d++)
        begin
            if (b_byp_reg && (b_byp_slot_reg == b_row_slot_reg[d]))
                col_vals[d] = b_pix_reg;
            else
                col_vals[d] = rd_reg[b_row_slot_reg[d]];
        end
    end

    always_comb
    begin
        for (int r = 0; r < TAPS; r++)
            for (int x = 0; x < TAPS; x++)
                win[r][x] = sr_reg[c_col_sel_reg[x]][r];
    end

    always_comb
    begin
        for (int k = 0; k < KERNELS; k++)
        begin
            for (int r = 0; r < TAPS; r++)
            begin
                part[k][r] = '0;
                for (int x = 0; x < TAPS; x++)
                    part[k][r] = part[k][r]
                               + sum_t'(KERNEL[k][r*TAPS+x]) * sum_t'(win[r][x]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < KERNELS; k++)
        begin
            ksum[k] = '0;
            for (int r = 0; r < TAPS; r++)
                ksum[k] = ksum[k] + p_part_reg[k][r];
        end
    end

    always_comb
    begin
        best = '0;
        mag  = '0;
        for (int k = 0; k < KERNELS; k++)
        begin
            mag = (s_sum_reg[k] < 0) ? mag_t'(-s_sum_reg[k]) : mag_t'(s_sum_reg[k]);
            if (mag > best)
                best = mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pop)
            begin
                b_emit_reg     <= cmd.emit;
                b_byp_reg      <= cmd.wr;
                b_byp_slot_reg <= cmd.wr_slot;
                b_pix_reg      <= pix;
                b_row_slot_reg <= cmd.row_slot;
                b_col_sel_reg  <= cmd.col_sel;
                b_row_reg      <= cmd.orow;
                b_col_reg      <= cmd.ocol;
                b_last_reg     <= cmd.last;
            end
            if (b_valid_reg)
            begin
                for (int i = 0; i < TAPS-1; i++)
                    sr_reg[i] <= sr_reg[i+1];
                sr_reg[TAPS-1] <= col_vals;
            end
            c_col_sel_reg <= b_col_sel_reg;
            c_row_reg     <= b_row_reg;
            c_col_reg     <= b_col_reg;
            c_last_reg    <= b_last_reg;
            p_part_reg    <= part;
            p_row_reg     <= c_row_reg;
            p_col_reg     <= c_col_reg;
            p_last_reg    <= c_last_reg;
            s_sum_reg     <= ksum;
            s_row_reg     <= p_row_reg;
            s_col_reg     <= p_col_reg;
            s_last_reg    <= p_last_reg;
            out_grad_reg  <= best[GW-1:0];
            out_row_reg   <= s_row_reg;
            out_col_reg   <= s_col_reg;
            out_last_reg  <= s_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= pop && cmd.fetch;
            c_valid_reg   <= b_valid_reg && b_emit_reg;
            p_valid_reg   <= c_valid_reg;
            s_valid_reg   <= p_valid_reg;
            out_valid_reg <= s_valid_reg;
        end
    end

    assign result_stream.valid        = out_valid_reg;
    assign result_stream.gradient_x16 = out_grad_reg;
    assign result_stream.out_row      = out_row_reg;
    assign result_stream.out_col      = out_col_reg;
    assign result_stream.frame_last   = out_last_reg;

    a_emit_needs_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.emit) |-> cmd.fetch)
        else $error("result word without a window column fetch");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s_valid_reg) && $stable(c_valid_reg))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

// File: design/directional_gradient_max_unit.sv
`default_nettype none

// The result for a pixel is released two lines and two pixels after it arrives.
// Throughput: one word per cycle in and out unless the output stalls, set by the
//   fetch of a 5-row column from the 8 line banks; drain words flush the last
//   results.
// Reset: counters cleared, size 1920x1080; line banks are not cleared.
module directional_gradient_max_unit
    import dgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    dgm_in_if.sink                pixel_stream,
    dgm_out_if.source             result_stream,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [DIM_W-1:0] cfg_data
);

    localparam int DATA_W = $bits(cmd_t) + PIXEL_BITS;

    logic              push, full, pop, empty;
    cmd_t              f_cmd, q_cmd;
    logic [DATA_W-1:0] q_din, q_dout;
    logic [PIXEL_BITS-1:0] q_pix;

    dgm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_stream (pixel_stream),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .queue_full   (full),
        .push         (push),
        .cmd          (f_cmd)
    );

    assign q_din = {f_cmd, pixel_stream.pixel};

    dgm_queue #(.DATA_W(DATA_W)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .full  (full),
        .pop   (pop),
        .dout  (q_dout),
        .empty (empty)
    );

    assign q_cmd = cmd_t'(q_dout[DATA_W-1:PIXEL_BITS]);
    assign q_pix = q_dout[PIXEL_BITS-1:0];

    dgm_back #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .cmd           (q_cmd),
        .pix           (q_pix),
        .pop           (pop),
        .result_stream (result_stream)
    );

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
    import dgm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_SYNC} act_e;

    typedef struct {
        act_e             kind;
        logic             op;
        logic [9:0]       px;
        logic             idx;
        logic [DIM_W-1:0] data;
    } action_t;

    typedef struct {
        logic [13:0] grad;
        logic [10:0] row;
        logic [10:0] col;
        logic        last;
    } result_t;

    localparam int TAP [4][25] = '{
        '{ 0, 0, 0, 0, 0,   1, 3, 8, 3, 1,   0, 0, 0, 0, 0,  -1,-3,-8,-3,-1,   0, 0, 0, 0, 0 },
        '{ 0, 0, 1, 0, 0,   0, 8, 3, 0, 0,   1, 3, 0,-3,-1,   0, 0,-3,-8, 0,   0, 0,-1, 0, 0 },
        '{ 0, 0, 1, 0, 0,   0, 0, 3, 8, 0,  -1,-3, 0, 3, 1,   0,-8,-3, 0, 0,   0, 0,-1, 0, 0 },
        '{ 0, 1, 0,-1, 0,   0, 3, 0,-3, 0,   0, 8, 0,-8, 0,   0, 3, 0,-3, 0,   0, 1, 0,-1, 0 }
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [DIM_W-1:0] cfg_data;

    dgm_in_if  #(.PIXEL_BITS(10)) pix_if ();
    dgm_out_if #(.PIXEL_BITS(10)) res_if ();

    directional_gradient_max_unit #(.MAX_WIDTH(2048), .PIXEL_BITS(10)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_stream  (pix_if),
        .result_stream (res_if),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    action_t actions[$];
    result_t expected_results[$];

    // predictor state
    logic [9:0]       line_mem [8][2048];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    int               in_row, in_col, out_row, out_col;
    bit               frame_in_done;

    int  mismatches;
    int  results_seen;
    int  words_since_idle;
    bit  in_fire, out_fire;
    int  tx_gap, rx_gap, long_hold, holds_done;
    bit  tx_burst, rx_burst;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int sat_width();
        return (width_reg < 3) ? 3 : (width_reg > 2048) ? 2048 : int'(width_reg);
    endfunction

    function automatic int sat_height();
        return (height_reg < 3) ? 3 : (height_reg > 2048) ? 2048 : int'(height_reg);
    endfunction

    function automatic int reflect(int p, int n);
        if (p < 0)
            p = -p;
        if (p >= n)
            p = 2 * n - 2 - p;
        if (p < 0)
            p = 0;
        if (p >= n)
            p = n - 1;
        return p;
    endfunction

    function automatic int max_gradient(int r, int c, int w, int h);
        int win [25];
        int best;
        int s;
        best = 0;
        for (int dy = -2; dy <= 2; dy++)
            for (int dx = -2; dx <= 2; dx++)
                win[(dy + 2) * 5 + dx + 2] =
                    line_mem[reflect(r + dy, h) % 8][reflect(c + dx, w)];
        for (int k = 0; k < 4; k++)
        begin
            s = 0;
            for (int i = 0; i < 25; i++)
                s += TAP[k][i] * win[i];
            if (s < 0)
                s = -s;
            if (s > best)
                best = s;
        end
        return best;
    endfunction

    function automatic void restart_frame();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        frame_in_done = 0;
    endfunction

    function automatic void release_result(int w, int h);
        result_t res;
        res.grad = 14'(max_gradient(out_row, out_col, w, h));
        res.row  = 11'(out_row);
        res.col  = 11'(out_col);
        res.last = (out_row == h - 1) && (out_col == w - 1);
        expected_results.push_back(res);
        if (res.last)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic void predict_word(logic op, logic [9:0] px);
        int w;
        int h;
        int n;
        w = sat_width();
        h = sat_height();
        if (op == OP_PIXEL && !frame_in_done)
        begin
            n = in_row * w + in_col;
            line_mem[in_row % 8][in_col] = px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    frame_in_done = 1;
                end
            end
            if (n >= 2 * w + 2)
                release_result(w, h);
        end
        else if (frame_in_done)
            release_result(w, h);
    endfunction

    // prediction on accepted words and config writes, checking of results
    always @(posedge clk)
    begin
        result_t exp_res;
        in_fire  <= pix_if.valid && pix_if.ready;
        out_fire <= res_if.valid && res_if.ready;
        if (pix_if.valid && pix_if.ready)
            words_since_idle <= 0;
        else
            words_since_idle <= words_since_idle + 1;
        if (rst_n && cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
                width_reg = cfg_data;
            else
                height_reg = cfg_data;
            restart_frame();
        end
        if (rst_n && pix_if.valid && pix_if.ready)
            predict_word(pix_if.op, pix_if.pixel);
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: grad %0d row %0d col %0d last %0d",
                             res_if.gradient_x16, res_if.out_row, res_if.out_col,
                             res_if.frame_last);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (res_if.gradient_x16 !== exp_res.grad || res_if.out_row !== exp_res.row ||
                    res_if.out_col !== exp_res.col || res_if.frame_last !== exp_res.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp grad %0d row %0d col %0d last %0d, got %0d %0d %0d %0d",
                                 exp_res.grad, exp_res.row, exp_res.col, exp_res.last,
                                 res_if.gradient_x16, res_if.out_row, res_if.out_col,
                                 res_if.frame_last);
                end
            end
        end
    end

    // pixel and config driver
    always @(negedge clk)
    begin
        logic    nv;
        logic    nwe;
        action_t act;
        nv  = pix_if.valid;
        nwe = 1'b0;
        if (rst_n)
        begin
            if (nv && in_fire)
                nv = 1'b0;
            if (!nv)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (actions.size() > 0)
                begin
                    act = actions[0];
                    case (act.kind)
                        ACT_WORD:
                        begin
                            void'(actions.pop_front());
                            pix_if.op    <= act.op;
                            pix_if.pixel <= act.px;
                            nv = 1'b1;
                            if ($urandom_range(0, 59) == 0)
                                tx_burst = !tx_burst;
                            tx_gap = tx_burst ? 0 : $urandom_range(0, 14);
                        end
                        ACT_CFG:
                        begin
                            if (expected_results.size() == 0 && words_since_idle >= 12)
                            begin
                                void'(actions.pop_front());
                                nwe = 1'b1;
                                cfg_index <= act.idx;
                                cfg_data  <= act.data;
                            end
                        end
                        default:
                        begin
                            if (expected_results.size() == 0)
                                void'(actions.pop_front());
                        end
                    endcase
                end
            end
            pix_if.valid <= nv;
            cfg_we       <= nwe;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold == 0 && holds_done < 2 && results_seen >= 150 + holds_done * 3000)
            begin
                long_hold = 600;
                holds_done++;
            end
            if (out_fire)
            begin
                if ($urandom_range(0, 59) == 0)
                    rx_burst = !rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(0, 14);
            end
            if (long_hold > 0)
            begin
                long_hold--;
                res_if.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic push_word(logic op, logic [9:0] px);
        action_t act;
        act.kind = ACT_WORD;
        act.op   = op;
        act.px   = px;
        act.idx  = CFG_WIDTH;
        act.data = '0;
        actions.push_back(act);
    endtask

    task automatic push_cfg(logic idx, logic [DIM_W-1:0] data);
        action_t act;
        act.kind = ACT_CFG;
        act.op   = OP_PIXEL;
        act.px   = '0;
        act.idx  = idx;
        act.data = data;
        actions.push_back(act);
    endtask

    task automatic push_sync();
        action_t act;
        act.kind = ACT_SYNC;
        act.op   = OP_PIXEL;
        act.px   = '0;
        act.idx  = CFG_WIDTH;
        act.data = '0;
        actions.push_back(act);
    endtask

    function automatic logic [9:0] pick_pixel(int style);
        case (style)
            0:       return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            1:       return 10'($urandom_range(0, 15));
            default: return 10'($urandom());
        endcase
    endfunction

    // one frame of w x h; cut > 0 stops the input after that many pixels
    task automatic push_frame(int w, int h, int cut, int noise, ref int count);
        int style;
        int total;
        style = $urandom_range(0, 3);
        total = (cut > 0) ? cut : w * h;
        for (int i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 99) < noise)
            begin
                push_word(OP_DRAIN, 10'($urandom()));
                count++;
            end
            push_word(OP_PIXEL, pick_pixel(style));
            count++;
        end
        if (cut == 0)
            for (int i = 0; i < 2 * w + 2; i++)
            begin
                push_word($urandom_range(0, 3) == 0 ? OP_PIXEL : OP_DRAIN, 10'($urandom()));
                count++;
            end
    endtask

    initial
    begin
        int w;
        int h;
        int count;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_WIDTH;
        cfg_data     = '0;
        pix_if.valid = 1'b0;
        pix_if.op    = OP_PIXEL;
        pix_if.pixel = '0;
        res_if.ready = 1'b0;
        width_reg    = 12'(WIDTH_RESET);
        height_reg   = 12'(HEIGHT_RESET);
        restart_frame();
        count = 0;

        // a few pixels at the reset size, then a 3x3 frame
        for (int i = 0; i < 4; i++)
            push_word(OP_PIXEL, 10'(i * 341));
        push_cfg(CFG_WIDTH, 12'd3);
        push_cfg(CFG_HEIGHT, 12'd3);
        push_word(OP_DRAIN, 10'd0);
        for (int i = 0; i < 9; i++)
            push_word(OP_PIXEL, (i % 2) ? 10'd1023 : 10'd0);
        for (int i = 0; i < 3; i++)
            push_word(OP_DRAIN, 10'd1023);
        push_word(OP_PIXEL, 10'd512);
        push_word(OP_PIXEL, 10'd1);
        for (int i = 0; i < 3; i++)
            push_word(OP_DRAIN, 10'd0);
        push_word(OP_DRAIN, 10'd0);
        push_sync();

        // saturated sizes: widest and tallest frames, cut short, then a full 3x3 frame
        push_cfg(CFG_WIDTH, 12'd4095);
        push_cfg(CFG_HEIGHT, 12'd2);
        push_frame(2048, 3, 150, 0, count);
        push_cfg(CFG_WIDTH, 12'd0);
        push_cfg(CFG_HEIGHT, 12'd4095);
        push_frame(3, 2048, 150, 2, count);
        push_cfg(CFG_WIDTH, 12'd1);
        push_cfg(CFG_HEIGHT, 12'd2048);
        push_cfg(CFG_HEIGHT, 12'd3);
        push_frame(3, 3, 0, 0, count);

        count = 0;
        w = 3;
        h = 3;
        while (count < 650)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                w = $urandom_range(3, 16);
                push_cfg(CFG_WIDTH, 12'(w));
            end
            if ($urandom_range(0, 2) != 0)
            begin
                h = $urandom_range(3, 12);
                push_cfg(CFG_HEIGHT, 12'(h));
            end
            if ($urandom_range(0, 9) == 0)
                push_frame(w, h, $urandom_range(1, w * h - 1), 5, count);
            else
                push_frame(w, h, 0, 5, count);
            if ($urandom_range(0, 4) == 0)
                push_sync();
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (actions.size() > 0 || pix_if.valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
design/dgm_pkg.sv
design/dgm_in_if.sv
design/dgm_out_if.sv
design/dgm_front.sv
design/dgm_queue.sv
design/dgm_back.sv
design/directional_gradient_max_unit.sv
test/testbench.sv
